### hdl/kfg_pkg.sv
// ----------------------------------------------------------------------------
// Kuwahara filter package
// Shared widths, register indexes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kfg_pkg;

    localparam int PIX_W      = 8;
    localparam int IMG_W_W    = 11;
    localparam int ROW_W      = 13;
    localparam int HALF_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Arithmetic widths for a quadrant of at most 8 by 8 pixels.
    localparam int SPAN_W     = 4;
    localparam int N_W        = 7;
    localparam int NN_W       = 13;
    localparam int SUM_W      = 14;
    localparam int SQ_W       = 22;
    localparam int T2_W       = 28;
    localparam int D_W        = 29;
    localparam int X_W        = 42;
    localparam int DIV_CNT_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_KERNEL  = 2'd2;

    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [ROW_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [HALF_W-1:0]  RST_HALF_KERNEL  = 3'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_CMP_MUL,
        ST_CMP_CROSS,
        ST_CMP_PICK,
        ST_DIV_LOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic cfg_we;
        logic capture;
        logic decide;
        logic init;
        logic scan;
        logic cmp_mul;
        logic cmp_cross;
        logic cmp_pick;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic scan_last;
        logic q_last;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

### hdl/kfg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/kfg_ctrl.sv
// ----------------------------------------------------------------------------
// Kuwahara filter controller
// Sequences one transaction through decide, window scan, quadrant compare,
// division and output load.
// ----------------------------------------------------------------------------
module kfg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cfg_valid,
    input  kfg_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output logic          o_cfg_ready,
    output kfg_pkg::t_cmd o_cmd
);

    kfg_pkg::t_state r_state;
    kfg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kfg_pkg::ST_IDLE: begin
                if (i_in_valid && !i_cfg_valid) begin
                    n_state = kfg_pkg::ST_DECIDE;
                end
            end
            kfg_pkg::ST_DECIDE: begin
                n_state = i_stat.emit ? kfg_pkg::ST_INIT : kfg_pkg::ST_IDLE;
            end
            kfg_pkg::ST_INIT:      n_state = kfg_pkg::ST_SCAN;
            kfg_pkg::ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = kfg_pkg::ST_SCAN_WAIT;
                end
            end
            kfg_pkg::ST_SCAN_WAIT: n_state = kfg_pkg::ST_CMP_MUL;
            kfg_pkg::ST_CMP_MUL:   n_state = kfg_pkg::ST_CMP_CROSS;
            kfg_pkg::ST_CMP_CROSS: n_state = kfg_pkg::ST_CMP_PICK;
            kfg_pkg::ST_CMP_PICK: begin
                n_state = i_stat.q_last ? kfg_pkg::ST_DIV_LOAD : kfg_pkg::ST_CMP_MUL;
            end
            kfg_pkg::ST_DIV_LOAD:  n_state = kfg_pkg::ST_DIV;
            kfg_pkg::ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = kfg_pkg::ST_OUT;
                end
            end
            kfg_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = kfg_pkg::ST_IDLE;
                end
            end
            default: n_state = kfg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            kfg_pkg::ST_IDLE: begin
                o_cfg_ready    = 1'b1;
                o_in_stall     = i_cfg_valid;
                o_cmd.cfg_we   = i_cfg_valid;
                o_cmd.capture  = i_in_valid && !i_cfg_valid;
            end
            kfg_pkg::ST_DECIDE:    o_cmd.decide    = 1'b1;
            kfg_pkg::ST_INIT:      o_cmd.init      = 1'b1;
            kfg_pkg::ST_SCAN:      o_cmd.scan      = 1'b1;
            kfg_pkg::ST_CMP_MUL:   o_cmd.cmp_mul   = 1'b1;
            kfg_pkg::ST_CMP_CROSS: o_cmd.cmp_cross = 1'b1;
            kfg_pkg::ST_CMP_PICK:  o_cmd.cmp_pick  = 1'b1;
            kfg_pkg::ST_DIV_LOAD:  o_cmd.div_load  = 1'b1;
            kfg_pkg::ST_DIV:       o_cmd.div_step  = 1'b1;
            kfg_pkg::ST_OUT:       o_cmd.out_load  = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### hdl/kfg_dp.sv
// ----------------------------------------------------------------------------
// Kuwahara filter datapath
// Configuration registers, frame counters, line store ring, quadrant
// accumulators, exact variance compare, mean division and output register.
// ----------------------------------------------------------------------------
module kfg_dp #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kfg_pkg::t_cmd                     i_cmd,
    output kfg_pkg::t_stat                    o_stat,
    input  logic [kfg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kfg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_func,
    input  logic [kfg_pkg::PIX_W-1:0]         i_pixel_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [kfg_pkg::PIX_W-1:0]         o_out_pixel,
    output logic                              o_frame_end
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = kfg_pkg::ROW_W;
    localparam int PW   = CW + RW;
    localparam int RING = MAX_WIDTH * (2 * MAX_HALF + 1) + 2 * MAX_HALF + 1;
    localparam int AW   = $clog2(RING);
    localparam int HW   = kfg_pkg::HALF_W;
    localparam int SW   = kfg_pkg::SPAN_W;

    // Ring address helpers; every offset stays below the ring depth.
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        logic [AW-1:0] res;
        res = (a == AW'(RING - 1)) ? '0 : a + AW'(1);
        return res;
    endfunction

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(RING)) begin
            s = s - (AW+1)'(RING);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW-1:0] res;
        if (a >= b) begin
            res = a - b;
        end else begin
            res = a + (AW'(RING) - b);
        end
        return res;
    endfunction

    // ---------------- configuration ----------------
    logic [kfg_pkg::IMG_W_W-1:0] r_image_width;
    logic [RW-1:0]               r_image_height;
    logic [HW-1:0]               r_half_kernel;
    logic                        cfg_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= kfg_pkg::RST_IMAGE_WIDTH;
            r_image_height <= kfg_pkg::RST_IMAGE_HEIGHT;
            r_half_kernel  <= kfg_pkg::RST_HALF_KERNEL;
        end else if (i_cmd.cfg_we) begin
            case (i_cfg_index)
                kfg_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[kfg_pkg::IMG_W_W-1:0];
                kfg_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[RW-1:0];
                kfg_pkg::CFG_HALF_KERNEL:  r_half_kernel  <= i_cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cfg_index)
            kfg_pkg::CFG_IMAGE_WIDTH,
            kfg_pkg::CFG_IMAGE_HEIGHT,
            kfg_pkg::CFG_HALF_KERNEL: cfg_clear = i_cmd.cfg_we;
            default:                  cfg_clear = 1'b0;
        endcase
    end

    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [HW-1:0] k_eff;
    logic [CW-1:0] w_m1;
    logic [CW-1:0] lag_tail;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_image_width);
        end
        h_eff    = (r_image_height == '0) ? RW'(1) : r_image_height;
        k_eff    = (r_half_kernel > HW'(MAX_HALF)) ? HW'(MAX_HALF) : r_half_kernel;
        w_m1     = w_eff - CW'(1);
        lag_tail = (CW'(k_eff) < w_m1) ? CW'(k_eff) : w_m1;
    end

    logic [PW-1:0] r_total;
    logic [PW-1:0] r_lag;

    always_ff @(posedge i_clk) begin
        r_total <= PW'(w_eff) * PW'(h_eff);
        r_lag   <= PW'(k_eff) * PW'(w_eff) + PW'(lag_tail);
    end

    // ---------------- input capture and counters ----------------
    logic                      r_func;
    logic [kfg_pkg::PIX_W-1:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_pix  <= i_pixel_value;
        end
    end

    logic [PW-1:0] r_p_in;
    logic [PW-1:0] r_p_out;
    logic [AW-1:0] r_wr_addr;
    logic [AW-1:0] r_base;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;

    logic          in_open;
    logic          out_open;
    logic          is_pix;
    logic [PW:0]   out_plus_lag;
    logic          last_out;
    logic          emit;

    always_comb begin
        in_open      = r_p_in < r_total;
        out_open     = r_p_out < r_total;
        is_pix       = !r_func && in_open;
        out_plus_lag = {1'b0, r_p_out} + {1'b0, r_lag};
        if (is_pix) begin
            emit = ({1'b0, r_p_in} >= out_plus_lag) && out_open;
        end else begin
            emit = !in_open && out_open;
        end
        last_out = ({1'b0, r_p_out} + (PW+1)'(1)) >= {1'b0, r_total};
    end

    assign o_stat.emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear || (i_cmd.out_load && last_out)) begin
            r_p_in    <= '0;
            r_p_out   <= '0;
            r_wr_addr <= '0;
            r_base    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            if (i_cmd.decide && is_pix) begin
                r_p_in    <= r_p_in + PW'(1);
                r_wr_addr <= ring_inc(r_wr_addr);
            end
            if (i_cmd.out_load) begin
                r_p_out <= r_p_out + PW'(1);
                r_base  <= ring_inc(r_base);
                if (r_out_col + CW'(1) >= w_eff) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + RW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    // ---------------- line store ----------------
    logic [AW-1:0]             r_cur_addr;
    logic [kfg_pkg::PIX_W-1:0] ram_rdata;

    kfg_ram #(
        .WIDTH(kfg_pkg::PIX_W),
        .DEPTH(RING)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.decide && is_pix),
        .i_waddr (r_wr_addr),
        .i_wdata (r_pix),
        .i_raddr (r_cur_addr),
        .o_rdata (ram_rdata)
    );

    // ---------------- window setup ----------------
    logic [HW-1:0] up_c, dn_c, lf_c, rt_c;
    logic [RW:0]   y_plus_k;
    logic [CW:0]   x_plus_k;
    logic [AW-1:0] start_off;

    always_comb begin
        up_c = (r_out_row >= RW'(k_eff)) ? k_eff : r_out_row[HW-1:0];
        lf_c = (r_out_col >= CW'(k_eff)) ? k_eff : r_out_col[HW-1:0];
        y_plus_k = {1'b0, r_out_row} + (RW+1)'(k_eff);
        x_plus_k = {1'b0, r_out_col} + (CW+1)'(k_eff);
        if (y_plus_k > {1'b0, h_eff - RW'(1)}) begin
            dn_c = HW'(h_eff - RW'(1) - r_out_row);
        end else begin
            dn_c = k_eff;
        end
        if (x_plus_k > {1'b0, w_m1}) begin
            rt_c = HW'(w_m1 - r_out_col);
        end else begin
            rt_c = k_eff;
        end
        start_off = AW'(up_c) * AW'(w_eff) + AW'(lf_c);
    end

    logic [HW-1:0] r_up, r_dn, r_lf, r_rt;
    logic [AW-1:0] r_row_addr;
    logic [SW-1:0] r_dr, r_dc;
    logic [SW-1:0] row_end, col_end;
    logic [AW-1:0] next_row_addr;

    assign row_end          = SW'(r_up) + SW'(r_dn);
    assign col_end          = SW'(r_lf) + SW'(r_rt);
    assign o_stat.scan_last = (r_dr == row_end) && (r_dc == col_end);
    assign next_row_addr    = ring_add(r_row_addr, AW'(w_eff));

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_up       <= up_c;
            r_dn       <= dn_c;
            r_lf       <= lf_c;
            r_rt       <= rt_c;
            r_row_addr <= ring_sub(r_base, start_off);
            r_cur_addr <= ring_sub(r_base, start_off);
            r_dr       <= '0;
            r_dc       <= '0;
        end else if (i_cmd.scan) begin
            if (r_dc == col_end) begin
                r_dc       <= '0;
                r_dr       <= r_dr + SW'(1);
                r_row_addr <= next_row_addr;
                r_cur_addr <= next_row_addr;
            end else begin
                r_dc       <= r_dc + SW'(1);
                r_cur_addr <= ring_inc(r_cur_addr);
            end
        end
    end

    // ---------------- quadrant accumulators ----------------
    // Quadrant order: top-left, top-right, bottom-left, bottom-right.
    logic                     r_acc_en;
    logic [3:0]               r_acc_q;
    logic [kfg_pkg::SUM_W-1:0] r_s  [4];
    logic [kfg_pkg::SQ_W-1:0]  r_sq [4];
    logic [2*kfg_pkg::PIX_W-1:0] pix_sq;
    logic top_f, bot_f, lft_f, rgt_f;

    assign top_f  = SW'(r_dr) <= SW'(r_up);
    assign bot_f  = SW'(r_dr) >= SW'(r_up);
    assign lft_f  = SW'(r_dc) <= SW'(r_lf);
    assign rgt_f  = SW'(r_dc) >= SW'(r_lf);
    assign pix_sq = ram_rdata * ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.scan;
        end
        r_acc_q <= {bot_f && rgt_f, bot_f && lft_f, top_f && rgt_f, top_f && lft_f};
    end

    always_ff @(posedge i_clk) begin
        for (int q = 0; q < 4; q++) begin
            if (i_cmd.init) begin
                r_s[q]  <= '0;
                r_sq[q] <= '0;
            end else if (r_acc_en && r_acc_q[q]) begin
                r_s[q]  <= r_s[q] + kfg_pkg::SUM_W'(ram_rdata);
                r_sq[q] <= r_sq[q] + kfg_pkg::SQ_W'(pix_sq);
            end
        end
    end

    // ---------------- exact variance compare ----------------
    logic [1:0]               r_q;
    logic [HW-1:0]            rows_m1, cols_m1;
    logic [kfg_pkg::N_W-1:0]  cur_n;
    logic                     cur_v;

    always_comb begin
        case (r_q)
            2'd0:    begin rows_m1 = r_up; cols_m1 = r_lf; end
            2'd1:    begin rows_m1 = r_up; cols_m1 = r_rt; end
            2'd2:    begin rows_m1 = r_dn; cols_m1 = r_lf; end
            default: begin rows_m1 = r_dn; cols_m1 = r_rt; end
        endcase
        cur_n = kfg_pkg::N_W'((SW'(rows_m1) + SW'(1)) * (SW'(cols_m1) + SW'(1)));
        cur_v = (rows_m1 != '0) && (cols_m1 != '0);
    end

    assign o_stat.q_last = (r_q == 2'd3);

    logic [kfg_pkg::D_W-1:0]   r_t1;
    logic [kfg_pkg::T2_W-1:0]  r_t2;
    logic [kfg_pkg::NN_W-1:0]  r_nn;
    logic [kfg_pkg::N_W-1:0]   r_cn;
    logic [kfg_pkg::SUM_W-1:0] r_cs;
    logic                      r_cv;
    logic [kfg_pkg::D_W-1:0]   r_d;
    logic [kfg_pkg::X_W-1:0]   r_lhs, r_rhs;
    logic [kfg_pkg::D_W-1:0]   diff;

    logic                      r_found;
    logic [kfg_pkg::D_W-1:0]   r_bd;
    logic [kfg_pkg::N_W-1:0]   r_bn;
    logic [kfg_pkg::NN_W-1:0]  r_bnn;
    logic [kfg_pkg::SUM_W-1:0] r_bs;

    assign diff = r_t1 - kfg_pkg::D_W'(r_t2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_mul) begin
            r_t1 <= kfg_pkg::D_W'(cur_n) * kfg_pkg::D_W'(r_sq[r_q]);
            r_t2 <= kfg_pkg::T2_W'(r_s[r_q]) * kfg_pkg::T2_W'(r_s[r_q]);
            r_nn <= kfg_pkg::NN_W'(cur_n) * kfg_pkg::NN_W'(cur_n);
            r_cn <= cur_n;
            r_cs <= r_s[r_q];
            r_cv <= cur_v;
        end
        if (i_cmd.cmp_cross) begin
            r_d   <= diff;
            r_lhs <= kfg_pkg::X_W'(diff) * kfg_pkg::X_W'(r_bnn);
            r_rhs <= kfg_pkg::X_W'(r_bd) * kfg_pkg::X_W'(r_nn);
        end
    end

    // With no valid quadrant the best stays 0 over 1, so the mean is 0.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_q     <= '0;
            r_found <= 1'b0;
            r_bd    <= '0;
            r_bn    <= kfg_pkg::N_W'(1);
            r_bnn   <= kfg_pkg::NN_W'(1);
            r_bs    <= '0;
        end else if (i_cmd.cmp_pick) begin
            r_q <= r_q + 2'd1;
            if (r_cv && (!r_found || (r_lhs < r_rhs))) begin
                r_found <= 1'b1;
                r_bd    <= r_d;
                r_bn    <= r_cn;
                r_bnn   <= r_nn;
                r_bs    <= r_cs;
            end
        end
    end

    // ---------------- mean division, one quotient bit a cycle ----------------
    logic [kfg_pkg::SUM_W-1:0]     r_num;
    logic [kfg_pkg::SUM_W-1:0]     r_quo;
    logic [kfg_pkg::N_W-1:0]       r_rem;
    logic [kfg_pkg::DIV_CNT_W-1:0] r_dcnt;
    logic [kfg_pkg::N_W:0]         rem_sh;
    logic                          q_bit;

    assign rem_sh          = {r_rem, r_num[kfg_pkg::SUM_W-1]};
    assign q_bit           = rem_sh >= {1'b0, r_bn};
    assign o_stat.div_last = (r_dcnt == kfg_pkg::DIV_CNT_W'(kfg_pkg::SUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num  <= r_bs;
            r_quo  <= '0;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= {r_num[kfg_pkg::SUM_W-2:0], 1'b0};
            r_quo  <= {r_quo[kfg_pkg::SUM_W-2:0], q_bit};
            r_rem  <= q_bit ? kfg_pkg::N_W'(rem_sh - {1'b0, r_bn}) : rem_sh[kfg_pkg::N_W-1:0];
            r_dcnt <= r_dcnt + kfg_pkg::DIV_CNT_W'(1);
        end
    end

    // Round half to even, then clamp to the pixel range.
    logic [kfg_pkg::N_W:0]     rem_x2;
    logic                      round_up;
    logic [kfg_pkg::SUM_W:0]   rounded;
    logic [kfg_pkg::PIX_W-1:0] mean_pix;

    always_comb begin
        rem_x2   = {r_rem, 1'b0};
        round_up = (rem_x2 > {1'b0, r_bn}) || ((rem_x2 == {1'b0, r_bn}) && r_quo[0]);
        rounded  = {1'b0, r_quo} + (kfg_pkg::SUM_W+1)'(round_up);
        if (rounded > (kfg_pkg::SUM_W+1)'(255)) begin
            mean_pix = '1;
        end else begin
            mean_pix = rounded[kfg_pkg::PIX_W-1:0];
        end
    end

    // ---------------- output register ----------------
    logic                      r_out_valid;
    logic [kfg_pkg::PIX_W-1:0] r_out_pixel;
    logic                      r_out_fe;

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_pixel <= mean_pix;
            r_out_fe    <= last_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_frame_end = r_out_fe;

endmodule

### hdl/kuwahara_filter_gray.sv
// ----------------------------------------------------------------------------
// Kuwahara filter, grayscale
// Edge-preserving smoothing of an 8-bit frame streamed in raster order.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the input channel (i_in_valid / o_in_stall) with
// i_func low; after the last pixel of a frame the source sends drain
// transactions (i_func high) to flush the outputs still owed. Each output
// transaction on o_out_valid / i_out_stall carries one filtered pixel, and
// o_frame_end marks the last pixel of the frame. Outputs trail inputs by
// half_kernel rows plus half_kernel pixels, at most one row less a pixel.
// The block works on one transaction at a time. A transaction that yields no
// output is accepted and decided. One that yields an output also passes
// through window setup, a scan of the clipped window that reads the line
// store once per pixel, four quadrant compares (multiply, cross-multiply,
// pick) and a 14-step mean divider before the output load.
// Configuration writes (i_cfg_valid / o_cfg_ready) are taken only while the
// block is idle; a write to width, height or half_kernel restarts the frame.
// Reset clears the frame counters and loads 640 x 480 with half_kernel 2. The
// output register lets the next transaction be accepted while a result waits;
// if the receiver stalls, the next result waits until the register frees up.
module kuwahara_filter_gray #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [kfg_pkg::PIX_W-1:0]      i_pixel_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [kfg_pkg::PIX_W-1:0]      o_out_pixel,
    output logic                           o_frame_end,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kfg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kfg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    kfg_pkg::t_cmd  s_cmd;
    kfg_pkg::t_stat s_stat;

    kfg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (s_stat),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (s_cmd)
    );

    kfg_dp #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HALF (MAX_HALF)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_stat        (s_stat),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_pixel   (o_out_pixel),
        .o_frame_end   (o_frame_end)
    );

    // A configuration write and an input transaction never share a cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready && i_in_valid && !o_in_stall))
        else $error("configuration write and input accepted together");

    // Once an input is accepted the block is busy on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (!o_cfg_ready && o_in_stall))
        else $error("block not busy after accepting an input");

    // An output is loaded only when the output register is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

endmodule
